FILE: sv/scnh_pkg.sv
// Shared types and constants of the segment/circle nearest-hit core.
// No dependencies.
package scnh_pkg;

    localparam int unsigned CoordW  = 16;
    localparam int unsigned IdW     = 32;
    localparam int unsigned RadW    = 14;
    localparam int unsigned TW      = 17;
    localparam int unsigned SlotW   = 6;
    localparam int unsigned TargetR = 256;
    localparam logic [TW-1:0] TOne  = 17'h10000;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [SlotW-1:0]   slot;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic               target_alive;
        logic [31:0]        target_id;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic [31:0]        hit_id;
        logic [16:0]        hit_t;
        logic signed [15:0] hit_x;
        logic signed [15:0] hit_y;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load_query;  // latch segment, clear best
        logic rd_issue;    // memory read of current slot
        logic eval_start;  // begin evaluating the entry just read
        logic write_entry; // table write
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic eval_done;
    } t_status;

endpackage

FILE: sv/scnh_datapath.sv
// Datapath: target table memory, dot products, serial divider, hit test.
// Depends on scnh_pkg.
module scnh_datapath #(
    parameter int unsigned ENTRIES = 64,
    parameter int unsigned AW = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  scnh_pkg::t_in_item   i_item,
    input  logic [13:0]          i_radius,
    input  scnh_pkg::t_cmd       i_cmd,
    input  logic [AW-1:0]        i_slot,
    output scnh_pkg::t_status    o_status,
    output scnh_pkg::t_out_item  o_best
);
    import scnh_pkg::*;

    logic signed [15:0] mem_x [ENTRIES];
    logic signed [15:0] mem_y [ENTRIES];
    logic [31:0]        mem_id [ENTRIES];
    logic [ENTRIES-1:0] r_alive;

    logic signed [15:0] r_cx, r_cy;
    logic [31:0]        r_cid;
    logic               r_calive;

    logic [AW-1:0]      wr_slot;
    logic               wr_ok;
    assign wr_slot = AW'(i_item.slot);
    assign wr_ok   = i_cmd.write_entry && ({26'd0, i_item.slot} < 32'(ENTRIES));

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem_x[wr_slot]  <= i_item.target_x;
            mem_y[wr_slot]  <= i_item.target_y;
            mem_id[wr_slot] <= i_item.target_id;
        end
        if (i_cmd.rd_issue) begin
            r_cx  <= mem_x[i_slot];
            r_cy  <= mem_y[i_slot];
            r_cid <= mem_id[i_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive  <= '0;
            r_calive <= 1'b0;
        end else begin
            if (wr_ok)
                r_alive[wr_slot] <= i_item.target_alive;
            if (i_cmd.rd_issue)
                r_calive <= r_alive[i_slot];
        end
    end

    // query registers
    logic signed [15:0] r_ax, r_ay;
    logic signed [16:0] r_dx, r_dy;
    logic [34:0]        r_len;
    logic [31:0]        r_r2;

    // per-entry evaluation sequencer
    typedef enum logic [2:0] {E_IDLE, E_MUL, E_SUM, E_DIV, E_PT, E_ERR, E_DIST, E_CMP} t_es;
    t_es r_es;
    logic signed [34:0] r_px, r_py;   // products
    logic [16:0]        r_t;
    logic [34:0]        r_rem;
    logic [4:0]         r_cnt;
    logic signed [16:0] r_hx, r_hy;
    logic signed [17:0] r_ex, r_ey;
    logic [37:0]        r_d2;
    logic               r_found;
    logic [16:0]        r_bt;
    logic [31:0]        r_bid;
    logic signed [15:0] r_bx, r_by;
    logic               r_done;

    logic signed [16:0] ox, oy;
    assign ox = 17'(r_cx) - 17'(r_ax);
    assign oy = 17'(r_cy) - 17'(r_ay);

    // 17x17 and 18x18 squares, full width
    logic signed [33:0] dx_sq, dy_sq;
    logic signed [35:0] ex_sq, ey_sq;
    assign dx_sq = r_dx * r_dx;
    assign dy_sq = r_dy * r_dy;
    assign ex_sq = r_ex * r_ex;
    assign ey_sq = r_ey * r_ey;

    logic signed [35:0] dot_sum;
    assign dot_sum = 36'(r_px) + 36'(r_py);

    logic [35:0] rem_sh;
    assign rem_sh = {r_rem, 1'b0};

    function automatic logic signed [16:0] pt_at(logic signed [15:0] a,
                                                 logic signed [16:0] d,
                                                 logic [16:0] t);
        logic signed [34:0] p;
        logic signed [34:0] q;
        p = 35'(d) * $signed({18'd0, t});
        q = (p + 35'sd32768) >>> 16;
        return 17'(a) + q[16:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_es    <= E_IDLE;
            r_found <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            // dead entry finishes at once, live one after the compare
            r_done <= ((r_es == E_IDLE) && i_cmd.eval_start && !r_calive) ||
                      (r_es == E_CMP);
            if (i_cmd.load_query) begin
                r_found <= 1'b0;
                r_bt <= '0; r_bid <= '0; r_bx <= '0; r_by <= '0;
                r_ax <= i_item.start_x;
                r_ay <= i_item.start_y;
                r_dx <= 17'(i_item.end_x) - 17'(i_item.start_x);
                r_dy <= 17'(i_item.end_y) - 17'(i_item.start_y);
                r_r2 <= 32'(({18'd0, i_radius} + 32'(TargetR))
                           * ({18'd0, i_radius} + 32'(TargetR)));
                r_len <= '0;
            end
            case (r_es)
                E_IDLE: if (i_cmd.eval_start) begin
                    if (r_calive) r_es <= E_MUL;
                    r_px <= 35'(ox) * 35'(r_dx);
                    r_len <= 35'(dx_sq);
                end
                E_MUL: begin
                    r_py  <= 35'(oy) * 35'(r_dy);
                    r_len <= r_len + 35'(dy_sq);
                    r_es  <= E_SUM;
                end
                E_SUM: begin
                    r_cnt <= 5'd16;
                    if (r_len == 0 || dot_sum <= 0) begin
                        r_t <= '0; r_es <= E_PT;
                    end else if (dot_sum >= $signed({1'b0, r_len})) begin
                        r_t <= TOne; r_es <= E_PT;
                    end else begin
                        r_t <= '0;
                        r_rem <= 35'(dot_sum);
                        r_es <= E_DIV;
                    end
                end
                E_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (rem_sh >= {1'b0, r_len}) begin
                        r_rem <= 35'(rem_sh - {1'b0, r_len});
                        r_t <= {r_t[15:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[34:0];
                        r_t <= {r_t[15:0], 1'b0};
                    end
                    if (r_cnt == 5'd1) r_es <= E_PT;
                    r_cnt <= r_cnt - 5'd1;
                end
                E_PT: begin
                    r_hx <= pt_at(r_ax, r_dx, r_t);
                    r_hy <= pt_at(r_ay, r_dy, r_t);
                    r_es <= E_ERR;
                end
                E_ERR: begin
                    r_ex <= 18'(r_hx) - 18'(r_cx);
                    r_ey <= 18'(r_hy) - 18'(r_cy);
                    r_es <= E_DIST;
                end
                E_DIST: begin
                    r_d2 <= 38'(ex_sq) + 38'(ey_sq);
                    r_es <= E_CMP;
                end
                E_CMP: begin
                    if (r_d2 <= {6'd0, r_r2} && (!r_found || r_t < r_bt)) begin
                        r_found <= 1'b1;
                        r_bt <= r_t; r_bid <= r_cid;
                        r_bx <= r_hx[15:0]; r_by <= r_hy[15:0];
                    end
                    r_es <= E_IDLE;
                end
                default: r_es <= E_IDLE;
            endcase
        end
    end

    assign o_status.eval_done = r_done;
    assign o_best.hit    = r_found;
    assign o_best.hit_id = r_bid;
    assign o_best.hit_t  = r_bt;
    assign o_best.hit_x  = r_bx;
    assign o_best.hit_y  = r_by;
endmodule

FILE: sv/scnh_ctrl.sv
// Controller: sequences writes and the walk over table entries for a query.
// Depends on scnh_pkg.
module scnh_ctrl #(
    parameter int unsigned ENTRIES = 64,
    parameter int unsigned AW = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_kind,
    output logic               o_in_stall,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic               o_out_zero,
    output scnh_pkg::t_cmd     o_cmd,
    output logic [AW-1:0]      o_slot,
    input  scnh_pkg::t_status  i_status
);
    import scnh_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_START, S_WAIT, S_OUT} t_state;
    t_state r_state;
    logic [AW:0] r_idx;
    logic        r_zero;
    logic        r_ov;
    logic        acc;

    assign acc = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || (r_ov && i_out_stall);
    assign o_out_valid = r_ov;
    assign o_out_zero = r_zero;
    assign o_slot = r_idx[AW-1:0];

    always_comb begin
        o_cmd = '0;
        o_cmd.write_entry = acc && (i_kind == KIND_WRITE);
        o_cmd.load_query  = acc && (i_kind == KIND_QUERY);
        o_cmd.rd_issue    = (r_state == S_READ);
        o_cmd.eval_start  = (r_state == S_START);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= '0;
            r_ov <= 1'b0;
            r_zero <= 1'b1;
        end else begin
            // a write taken as the old result leaves reloads the output instead
            if (r_ov && !i_out_stall && !o_cmd.write_entry) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: if (acc) begin
                    if (i_kind == KIND_WRITE) begin
                        r_ov <= 1'b1; r_zero <= 1'b1;
                    end else begin
                        r_idx <= '0; r_state <= S_READ;
                    end
                end
                S_READ:  r_state <= S_START;
                S_START: r_state <= S_WAIT;
                S_WAIT: if (i_status.eval_done) begin
                    if (r_idx == (AW+1)'(ENTRIES - 1)) r_state <= S_OUT;
                    else begin
                        r_idx <= r_idx + 1'b1; r_state <= S_READ;
                    end
                end
                S_OUT: if (!r_ov) begin
                    r_ov <= 1'b1; r_zero <= 1'b0; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: sv/segment_circle_nearest_hit_core.sv
// Top level of the segment/circle nearest-hit core.
// Depends on scnh_pkg, scnh_ctrl and scnh_datapath.
// A write transaction (kind 0) stores one target and its all-zero result is
// valid the cycle after acceptance. A query transaction (kind 1) walks every
// table entry in slot order: a registered memory read, the two dot-product
// multiplies, a sum, a serial restoring divider for t when t lies strictly
// between 0 and 1, then hit point, error, squared distance and compare. A
// dead entry finishes after its read; an alive entry with clamped t skips
// the divider. Only one transaction is in flight; the result sits in an
// output register until taken. No clearing pass: alive marks are
// flip-flops cleared at reset.
module segment_circle_nearest_hit_core #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  scnh_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output scnh_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [13:0]          i_cfg_data
);
    import scnh_pkg::*;

    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [13:0] r_radius;
    t_cmd        cmd;
    t_status     status;
    t_out_item   best;
    logic [AW-1:0] slot;
    logic        out_zero;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_radius <= '0;
        else if (i_cfg_valid) r_radius <= i_cfg_data;
    end

    scnh_ctrl #(.ENTRIES(ENTRIES), .AW(AW)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_kind(i_in_data.kind), .o_in_stall,
        .i_out_stall, .o_out_valid, .o_out_zero(out_zero),
        .o_cmd(cmd), .o_slot(slot), .i_status(status)
    );

    scnh_datapath #(.ENTRIES(ENTRIES), .AW(AW)) u_dp (
        .i_clk, .i_rst_n, .i_item(i_in_data), .i_radius(r_radius),
        .i_cmd(cmd), .i_slot(slot), .o_status(status), .o_best(best)
    );

    // write results are all zero; query results show the best-so-far
    assign o_out_data = out_zero ? '0 : best;

    // nothing accepted while a query is walking the table
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.eval_start |-> o_in_stall)
        else $error("input accepted during evaluation");
    // a finished result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped while stalled");
    // no hit means an empty result
    a_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.hit) |-> (o_out_data.hit_id == '0))
        else $error("id without hit");
endmodule
